// File: design/chtab_pkg.sv
package chtab_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int LEN_W       = 11;
  localparam int CFG_W       = 9;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  localparam logic             KIND_INSERT     = 1'b0;
  localparam logic             KIND_LOOKUP     = 1'b1;
  localparam logic [VAL_W-1:0] NOT_FOUND_VALUE = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0] CFG_RESET       = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic clr;       // clear one bucket head, advance sweep
    logic load;      // capture the input transaction, start the divider
    logic div_step;  // one restoring division step
    logic decide;    // head entry is on the read port: insert or set up walk
    logic walk;      // compare one chain node
    logic out_load;  // move the pending result to the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic walk_go;
    logic walk_end;
  } dp_status_t;

endpackage

// File: design/chtab_ram.sv
module chtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: design/chtab_dp.sv
module chtab_dp #(
  parameter int BUCKETS = 256,
  parameter int NODES   = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [chtab_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                 in_tuser,
  input  logic [chtab_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  chtab_pkg::ctrl_cmd_t                 cmd,
  output chtab_pkg::dp_status_t                st,
  output logic [chtab_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [chtab_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  localparam int KW  = chtab_pkg::KEY_W;
  localparam int VW  = chtab_pkg::VAL_W;
  localparam int CFW = chtab_pkg::CFG_W;
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW  = $clog2(NODES + 1);
  localparam int HW  = 1 + NW + CW;
  localparam int NDW = KW + VW + NW;
  localparam int DCW = $clog2(KW);

  logic [CFW-1:0] bucket_count_r;
  logic [CFW-1:0] eff;
  logic           kind_r;
  logic [KW-1:0]  key_r;
  logic [VW-1:0]  value_r;
  logic [KW-1:0]  key_sh_r;
  logic [CFW-1:0] div_r;
  logic [CFW-1:0] rem_r;
  logic [CFW-1:0] rem_nxt;
  logic [CFW:0]   rem_sh;
  logic [DCW-1:0] div_cnt_r;
  logic [BW-1:0]  bucket;
  logic [BW-1:0]  clr_addr_r;
  logic [CW-1:0]  next_free_r;
  logic [CW-1:0]  left_r;
  logic           pool_full;

  logic           res_found_r;
  logic [VW-1:0]  res_value_r;
  logic [CW-1:0]  res_len_r;
  logic           res_full_r;

  logic           head_we;
  logic [BW-1:0]  head_waddr;
  logic [HW-1:0]  head_wdata;
  logic [HW-1:0]  head_rdata;
  logic           h_valid;
  logic [NW-1:0]  h_idx;
  logic [CW-1:0]  h_len;

  logic           node_we;
  logic [NDW-1:0] node_wdata;
  logic [NW-1:0]  node_raddr;
  logic [NDW-1:0] node_rdata;
  logic [KW-1:0]  n_key;
  logic [VW-1:0]  n_value;
  logic [NW-1:0]  n_next;
  logic           n_match;

  // zero means one bucket; saturate at the table size
  always_comb begin
    if (bucket_count_r == '0) begin
      eff = CFW'(1);
    end else if (32'(bucket_count_r) > 32'(BUCKETS)) begin
      eff = CFW'(BUCKETS);
    end else begin
      eff = bucket_count_r;
    end
  end

  // restoring division, one quotient bit per step; only the remainder is kept
  assign rem_sh = {rem_r, key_sh_r[KW-1]};
  always_comb begin
    if (rem_sh >= {1'b0, div_r}) begin
      rem_nxt = CFW'(rem_sh - {1'b0, div_r});
    end else begin
      rem_nxt = rem_sh[CFW-1:0];
    end
  end

  assign bucket = BW'(rem_r);

  assign h_valid = head_rdata[HW-1];
  assign h_idx   = head_rdata[CW +: NW];
  assign h_len   = h_valid ? head_rdata[CW-1:0] : '0;

  assign n_next  = node_rdata[NW-1:0];
  assign n_value = node_rdata[NW +: VW];
  assign n_key   = node_rdata[NW + VW +: KW];
  assign n_match = (n_key == key_r);

  assign pool_full = (next_free_r == CW'(NODES));

  assign head_we    = cmd.clr || (cmd.decide && kind_r == chtab_pkg::KIND_INSERT && !pool_full);
  assign head_waddr = cmd.clr ? clr_addr_r : bucket;
  assign head_wdata = cmd.clr ? '0 : {1'b1, NW'(next_free_r), CW'(h_len + CW'(1))};

  assign node_we    = cmd.decide && kind_r == chtab_pkg::KIND_INSERT && !pool_full;
  assign node_wdata = {key_r, value_r, h_idx};
  // follow the chain one node per cycle
  assign node_raddr = cmd.walk ? n_next : h_idx;

  chtab_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_head_ram (
    .clk     (clk),
    .we      (head_we),
    .waddr   (head_waddr),
    .wdata   (head_wdata),
    .raddr   (bucket),
    .rdata_r (head_rdata)
  );

  chtab_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (NW'(next_free_r)),
    .wdata   (node_wdata),
    .raddr   (node_raddr),
    .rdata_r (node_rdata)
  );

  assign st.clr_last = (clr_addr_r == BW'(BUCKETS - 1));
  assign st.div_last = (div_cnt_r == DCW'(KW - 1));
  assign st.walk_go  = (kind_r == chtab_pkg::KIND_LOOKUP) && (h_len != '0);
  assign st.walk_end = n_match || (left_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= chtab_pkg::CFG_RESET;
      clr_addr_r     <= '0;
      next_free_r    <= '0;
    end else begin
      if (cfg_we) begin
        bucket_count_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + BW'(1);
      end
      if (node_we) begin
        next_free_r <= next_free_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_tuser;
      key_r     <= in_tdata[KW-1:0];
      value_r   <= in_tdata[KW +: VW];
      key_sh_r  <= in_tdata[KW-1:0];
      div_r     <= eff;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      key_sh_r  <= {key_sh_r[KW-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
    if (cmd.decide) begin
      left_r      <= h_len;
      res_found_r <= 1'b0;
      res_value_r <= chtab_pkg::NOT_FOUND_VALUE;
      res_full_r  <= 1'b0;
      res_len_r   <= h_len;
      if (kind_r == chtab_pkg::KIND_INSERT) begin
        if (pool_full) begin
          res_full_r <= 1'b1;
        end else begin
          res_len_r <= CW'(h_len + CW'(1));
        end
      end
    end
    if (cmd.walk) begin
      left_r <= left_r - CW'(1);
      if (n_match) begin
        res_found_r <= 1'b1;
        res_value_r <= n_value;
      end
    end
    if (cmd.out_load) begin
      out_tdata <= chtab_pkg::OUT_TDATA_W'({chtab_pkg::LEN_W'(res_len_r), res_value_r});
      out_tuser <= {res_full_r, res_found_r};
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= CW'(NODES))
    else $error("node pool counter past pool size");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> left_r != '0)
    else $error("chain walk with no nodes left");

endmodule

// File: design/chtab_ctrl.sv
module chtab_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  chtab_pkg::dp_status_t st,
  output chtab_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_HREAD,
    S_DECIDE,
    S_WALK,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_tvalid_r;
  logic   out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_HREAD;
        end
      end
      S_HREAD: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = st.walk_go ? S_WALK : S_FIN;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_DIV)
    else $error("accepted transaction did not start the divider");

  a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !st.walk_end) |=> state_r == S_WALK)
    else $error("chain walk left early");

endmodule

// File: design/chained_hash_table.sv
// channel  | direction | tdata                                  | tuser
// in_      | slave     | [31:0] key, [63:32] value              | [0] kind (0 insert, 1 lookup)
// out_     | master    | [31:0] value_out, [42:32] chain_length | [0] found, [1] pool_full
// cfg_     | write     | cfg_wdata[8:0] bucket_count            | -
//
// From accept to result an item passes through the bit-serial key modulo
// bucket count, one head-memory read, one decide step, a walk of the chain
// at one node-memory read per node (none for inserts and empty buckets, else
// up to the matching node or the end of the chain), and the output register load.
// After reset the head memory is swept, one bucket per cycle, before
// in_tready rises. A stalled output register holds the finished item.
module chained_hash_table #(
  parameter int BUCKETS = 256,
  parameter int NODES   = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [chtab_pkg::CFG_W-1:0]          cfg_wdata,   // bucket_count
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [chtab_pkg::IN_TDATA_W-1:0]     in_tdata,    // key, value
  input  logic                                 in_tuser,    // kind
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [chtab_pkg::OUT_TDATA_W-1:0]    out_tdata,   // value_out, chain_length, pad
  output logic [chtab_pkg::OUT_TUSER_W-1:0]    out_tuser    // found, pool_full
);

  chtab_pkg::ctrl_cmd_t  cmd;
  chtab_pkg::dp_status_t st;

  chtab_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  chtab_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
